// File: rtl/kbsc_pkg.sv
// Shared types, scan code constants and character tables for the set-1
// scan code translator. No dependencies.
package kbsc_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned MapLen = 59;
  localparam int unsigned IdxW   = $clog2(MapLen);

  // Modifier make and break codes
  localparam logic [CodeW-1:0] CODE_LSHIFT_MAKE  = 8'd42;
  localparam logic [CodeW-1:0] CODE_RSHIFT_MAKE  = 8'd54;
  localparam logic [CodeW-1:0] CODE_CTRL_MAKE    = 8'd29;
  localparam logic [CodeW-1:0] CODE_LSHIFT_BREAK = 8'd170;
  localparam logic [CodeW-1:0] CODE_RSHIFT_BREAK = 8'd182;
  localparam logic [CodeW-1:0] CODE_CTRL_BREAK   = 8'd157;
  // First code treated as a release
  localparam logic [CodeW-1:0] CODE_BREAK_MIN    = 8'd129;

  localparam logic [CharW-1:0] PLAIN_MAP [0:MapLen-1] = '{
    7'd0,   7'd0,   7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0
  };

  localparam logic [CharW-1:0] SHIFTED_MAP [0:MapLen-1] = '{
    7'd0,   7'd0,   7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
    7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd0,
    7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
    7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
    7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
    7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
    7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0
  };

  // Decode of one code against the current modifier flags
  typedef struct packed {
    logic             has_result;
    logic             caret;
    logic [CharW-1:0] ch;
    logic             shift_next;
    logic             ctrl_next;
  } dec_t;

endpackage

// File: rtl/kbsc_decode.sv
// Combinational decode of one scan code: modifier flag update and table
// lookup. Depends on kbsc_pkg.
module kbsc_decode (
  input  logic [kbsc_pkg::CodeW-1:0] code,
  input  logic                       shift_held,
  input  logic                       ctrl_held,
  output kbsc_pkg::dec_t             dec
);
  import kbsc_pkg::*;

  logic             in_map;
  logic [IdxW-1:0]  idx;
  logic [CharW-1:0] plain_ch;
  logic [CharW-1:0] shift_ch;

  assign in_map   = (code < CodeW'(MapLen));
  assign idx      = code[IdxW-1:0];
  assign plain_ch = in_map ? PLAIN_MAP[idx] : '0;
  assign shift_ch = in_map ? SHIFTED_MAP[idx] : '0;

  always_comb begin
    dec.has_result = 1'b0;
    dec.caret      = 1'b0;
    dec.ch         = '0;
    dec.shift_next = shift_held;
    dec.ctrl_next  = ctrl_held;
    if (code >= CODE_BREAK_MIN) begin
      if (code == CODE_LSHIFT_BREAK || code == CODE_RSHIFT_BREAK) begin
        dec.shift_next = 1'b0;
      end else if (code == CODE_CTRL_BREAK) begin
        dec.ctrl_next = 1'b0;
      end
    end else if (code == CODE_LSHIFT_MAKE || code == CODE_RSHIFT_MAKE) begin
      dec.shift_next = 1'b1;
    end else if (code == CODE_CTRL_MAKE) begin
      dec.ctrl_next = 1'b1;
    end else begin
      dec.has_result = 1'b1;
      // shifted table wins when both modifiers are down, and no caret then
      dec.caret      = ctrl_held & ~shift_held;
      dec.ch         = shift_held ? shift_ch : plain_ch;
    end
  end

endmodule

// File: rtl/keyboard_scancode_to_ascii.sv
// Top level of the set-1 scan code translator: input register, modifier
// flags and result register around kbsc_decode. Depends on kbsc_pkg and kbsc_decode.

// One scan code beat is taken per clock while the result side keeps up. A code
// waits in the input register, is decoded against the shift/ctrl flags as it
// moves on, and a character result appears on the master side the next cycle;
// sustained rate is one code per cycle while the result side keeps up. Modifier
// make/break codes update the flags; they and other releases give no result
// beat. With the result register full and stalled, the input register holds
// one more code before s_tready drops.
module keyboard_scancode_to_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] key_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] caret_prefix, [7:1] ascii_char
);
  import kbsc_pkg::*;

  logic             s1_valid;
  logic [CodeW-1:0] s1_code;
  logic             s1_move;
  logic             shift_held;
  logic             ctrl_held;
  logic             out_caret;
  logic [CharW-1:0] out_char;
  dec_t             dec;

  kbsc_decode u_decode (
    .code       (s1_code),
    .shift_held (shift_held),
    .ctrl_held  (ctrl_held),
    .dec        (dec)
  );

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_code <= s_tdata[CodeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
    end else if (s1_move) begin
      shift_held <= dec.shift_next;
      ctrl_held  <= dec.ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= dec.has_result;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && dec.has_result) begin
      out_caret <= dec.caret;
      out_char  <= dec.ch;
    end
  end

  assign m_tdata = {out_char, out_caret};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && !s1_valid)
    else $error("valid set after reset");

  a_shift_make: assert property (@(posedge clk) disable iff (rst)
    (s1_move && (s1_code == CODE_LSHIFT_MAKE || s1_code == CODE_RSHIFT_MAKE))
      |=> shift_held)
    else $error("shift make did not set flag");

  a_ctrl_break: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_code == CODE_CTRL_BREAK) |=> !ctrl_held)
    else $error("ctrl break did not clear flag");

  a_no_caret_shifted: assert property (@(posedge clk) disable iff (rst)
    (s1_move && dec.has_result && shift_held) |=> (m_tvalid && !out_caret))
    else $error("caret with shift held");

  a_rise_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_move && dec.has_result))
    else $error("result beat without a character code");

endmodule
